// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tosc_pkg.sv =====
// ----------------------------------------------------------------------------
// tosc_pkg
// Types, constants and helper functions of the oscillation profile block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tosc_pkg;

  localparam int FRAC_BITS = 16;

  // Shared arithmetic unit widths.
  localparam int OPA_W    = 56;
  localparam int OPB_W    = 35;
  localparam int MULB_W   = 32;
  localparam int PROD_W   = OPA_W + MULB_W;
  localparam int DIVN_W   = 48;
  localparam int ROOT_W   = 24;
  localparam int SQREM_W  = ROOT_W + 2;
  localparam int CNT_W    = 6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_AMPLITUDE  = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED  = 3'd1;
  localparam logic [2:0] CFG_ACCEL_RATE = 3'd2;
  localparam logic [2:0] CFG_DECEL_RATE = 3'd3;
  localparam logic [2:0] CFG_START_NEG  = 3'd4;

  // Configuration reset values.
  localparam logic [19:0] AMP_RST   = 20'd98304;
  localparam logic [20:0] SPEED_RST = 21'd65536;
  localparam logic [22:0] ACCEL_RST = 23'd196608;
  localparam logic [22:0] DECEL_RST = 23'd196608;

  // Profile phase codes.
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_CHK,
    ST_T_K,
    ST_D_SEL,
    ST_D_ACC1,
    ST_D_ACC2,
    ST_D_CRU,
    ST_D_DEC1,
    ST_D_DEC2,
    ST_D_DEC3,
    ST_D_FIN,
    ST_OUT,
    ST_B_VV,
    ST_B_AD,
    ST_B_DD,
    ST_B_CMP,
    ST_B_CT,
    ST_B_AB,
    ST_B_H,
    ST_B_DH,
    ST_B_PK,
    ST_B_PP,
    ST_B_AD2,
    ST_B_AT,
    ST_B_DT
  } seq_state_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Limit a distance to the segment length.
  function automatic logic [20:0] clamp_len(input logic [63:0] x, input logic [20:0] d);
    return (x > {43'd0, d}) ? d : x[20:0];
  endfunction

  // Move from an origin by len in the given direction, saturating to 22 bits.
  function automatic logic signed [21:0] step_end(input logic signed [21:0] org,
                                                  input logic neg,
                                                  input logic [20:0] len);
    logic signed [23:0] o;
    logic signed [23:0] l;
    logic signed [23:0] r;
    o = {{2{org[21]}}, org};
    l = {3'b000, len};
    r = neg ? (o - l) : (o + l);
    if (r > 24'sd2097151) begin
      return 22'sh1FFFFF;
    end else if (r < -24'sd2097152) begin
      return 22'sh200000;
    end
    return r[21:0];
  endfunction

endpackage

// ===== rtl/core/tosc_alu.sv =====
// ----------------------------------------------------------------------------
// tosc_alu
// Shared bit-serial unit: multiply, restoring divide and integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tosc_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  tosc_pkg::alu_req_t   req,
  input  logic [55:0]          opa,
  input  logic [34:0]          opb,
  output tosc_pkg::alu_sts_t   sts,
  output logic [87:0]          result,
  output logic [34:0]          remainder
);
  import tosc_pkg::*;

  logic                busy;
  logic                done;
  alu_op_t             op_r;
  logic [CNT_W-1:0]    cnt;
  logic [PROD_W-1:0]   prod;
  logic [OPA_W-1:0]    mcand;
  logic [DIVN_W-1:0]   div_q;
  logic [OPB_W-1:0]    div_r;
  logic [OPB_W-1:0]    divisor;
  logic [DIVN_W-1:0]   sq_val;
  logic [ROOT_W-1:0]   sq_root;
  logic [SQREM_W-1:0]  sq_rem;

  logic [OPA_W:0]      mul_sum;
  logic [OPB_W:0]      div_r2;
  logic [OPB_W:0]      div_sub;
  logic                div_ge;
  logic [SQREM_W+1:0]  sq_r2;
  logic [SQREM_W+1:0]  sq_trial;
  logic                sq_ge;

  // One multiplier bit, one quotient bit or one root bit per cycle.
  always_comb begin
    mul_sum  = {1'b0, prod[PROD_W-1:MULB_W]} + (prod[0] ? {1'b0, mcand} : '0);
    div_r2   = {div_r, div_q[DIVN_W-1]};
    div_ge   = div_r2 >= {1'b0, divisor};
    div_sub  = div_r2 - {1'b0, divisor};
    sq_r2    = {sq_rem, sq_val[DIVN_W-1:DIVN_W-2]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_ge    = sq_r2 >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= ALU_MUL;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op_r <= req.op;
        case (req.op)
          ALU_MUL:  cnt <= CNT_W'(MULB_W - 1);
          ALU_DIV:  cnt <= CNT_W'(DIVN_W - 1);
          ALU_SQRT: cnt <= CNT_W'(ROOT_W - 1);
          default:  cnt <= '0;
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      prod    <= {{OPA_W{1'b0}}, opb[MULB_W-1:0]};
      mcand   <= opa;
      div_q   <= opa[DIVN_W-1:0];
      div_r   <= '0;
      divisor <= opb;
      sq_val  <= opa[DIVN_W-1:0];
      sq_root <= '0;
      sq_rem  <= '0;
    end else if (busy) begin
      case (op_r)
        ALU_MUL: begin
          prod <= {mul_sum, prod[MULB_W-1:1]};
        end
        ALU_DIV: begin
          div_q <= {div_q[DIVN_W-2:0], div_ge};
          div_r <= div_ge ? div_sub[OPB_W-1:0] : div_r2[OPB_W-1:0];
        end
        ALU_SQRT: begin
          sq_val  <= {sq_val[DIVN_W-3:0], 2'b00};
          sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
          sq_rem  <= sq_ge ? SQREM_W'(sq_r2 - sq_trial) : sq_r2[SQREM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (op_r)
      ALU_MUL:  result = prod;
      ALU_DIV:  result = {{(PROD_W-DIVN_W){1'b0}}, div_q};
      ALU_SQRT: result = {{(PROD_W-ROOT_W){1'b0}}, sq_root};
      default:  result = '0;
    endcase
  end

  assign remainder = div_r;
  assign sts.busy  = busy;
  assign sts.done  = done;

endmodule

// ===== rtl/core/trapezoid_oscillation_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_oscillation_profile
// Back-and-forth position generator with trapezoidal speed segments.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat carries
//   in       sink       tick_time (elapsed time, Q0.16 seconds)
//   out      source     position_offset, moving_negative, phase
//   cfg      sink       cfg_index, cfg_data (register write)
//
// Each step on the shared unit runs its iterations between a start and a
// done. A tick of zero time goes straight to the output step. A tick inside
// a segment takes one to three multiplies plus control. A tick that ends a
// segment adds a profile rebuild and a division. After reset, and after
// every accepted write to a known register index, the profile is rebuilt
// (as a trapezoid or as a triangle) and in_ready stays low until it is
// done.
// A finished result waits in the output register; the next tick may be
// accepted meanwhile, and a later result waits for that register to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoid_oscillation_profile (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        tick_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] position_offset,
  output logic               moving_negative,
  output logic [1:0]         phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tosc_pkg::*;

  // Configuration registers. The start direction is only ever copied into
  // the heading before the first movement, so it needs no register of its own.
  logic [19:0] amp;
  logic [20:0] vmax;
  logic [22:0] acc_rate;
  logic [22:0] dec_rate;

  // Motion state.
  logic signed [21:0] offset_now;
  logic signed [21:0] origin;
  logic [20:0]        seg_len;
  logic [31:0]        seg_time;
  logic               heading;
  logic               moved;

  // Profile words of the current segment.
  logic [31:0] w_at;
  logic [31:0] w_ct;
  logic [31:0] w_dt;
  logic [31:0] w_pk;
  logic [31:0] w_ad;
  logic [31:0] w_cd;

  // Working registers of the sequencer.
  logic [55:0] t_x;
  logic [49:0] t_y;
  logic [47:0] t_ad;
  logic [47:0] t_dd;
  logic [47:0] t_ct;
  logic [23:0] t_pk;
  logic [20:0] t_cd;
  logic [31:0] t_e;
  logic [31:0] t_r;
  logic [20:0] t_s;
  logic        ret_tick;

  seq_state_t state;
  seq_state_t state_next;

  // Shared unit interface.
  alu_req_t    alu_req;
  alu_sts_t    alu_sts;
  logic [55:0] alu_opa;
  logic [34:0] alu_opb;
  logic [87:0] alu_res;
  logic [34:0] alu_rem;
  logic        op_state;
  logic        pend;

  // Derived operands: zero registers count as one LSB.
  logic [20:0] v1;
  logic [22:0] a1;
  logic [22:0] b1;
  logic [20:0] d1;
  logic [23:0] two_a;
  logic [23:0] two_b;
  logic [23:0] a_plus_b;
  logic [33:0] dur_sum;
  logic [33:0] dur;
  logic [32:0] e_sum;
  logic [31:0] e_ep;
  logic [31:0] e_epp;
  logic [31:0] p_ep;
  logic [48:0] ad_dd;
  logic [63:0] cru_sum;
  logic [49:0] dec_tot;
  logic [54:0] q_dec;
  logic [49:0] dec_diff;
  logic        in_take;
  logic        cfg_take;
  logic        out_free;
  logic [1:0]  phase_now;

  always_comb begin
    v1       = (vmax == '0) ? 21'd1 : vmax;
    a1       = (acc_rate == '0) ? 23'd1 : acc_rate;
    b1       = (dec_rate == '0) ? 23'd1 : dec_rate;
    d1       = (seg_len == '0) ? 21'd1 : seg_len;
    two_a    = {a1, 1'b0};
    two_b    = {b1, 1'b0};
    a_plus_b = {1'b0, a1} + {1'b0, b1};
    dur_sum  = {2'b00, w_at} + {2'b00, w_ct} + {2'b00, w_dt};
    dur      = (dur_sum == '0) ? 34'd1 : dur_sum;
    e_sum    = {1'b0, seg_time} + {17'd0, tick_time};
    e_ep     = t_e - w_at;
    e_epp    = e_ep - w_ct;
    p_ep     = seg_time - w_at;
    ad_dd    = {1'b0, t_ad} + {1'b0, t_dd};
    cru_sum  = {32'd0, w_ad} + {16'd0, alu_res[63:16]};
    dec_tot  = {18'd0, w_ad} + {18'd0, w_cd} + {2'd0, alu_res[63:16]};
    q_dec    = alu_res[87:33];
    dec_diff = ({5'd0, q_dec[49:0]} > {5'd0, t_y} || q_dec[54:50] != '0) ? '0
               : (t_y - q_dec[49:0]);
    in_ready  = (state == ST_IDLE);
    cfg_ready = (state == ST_IDLE) && !in_valid;
    in_take   = in_valid && in_ready;
    cfg_take  = cfg_valid && cfg_ready;
    out_free  = !out_valid || out_ready;
  end

  // Phase of the current segment time.
  always_comb begin
    if (seg_time == '0 || seg_time < w_at) begin
      phase_now = PH_ACCEL;
    end else if (p_ep < w_ct) begin
      phase_now = PH_CRUISE;
    end else begin
      phase_now = PH_DECEL;
    end
  end

  // Sequencer: next state and shared-unit operands.
  always_comb begin
    state_next = state;
    op_state   = 1'b0;
    alu_req.op = ALU_MUL;
    alu_opa    = '0;
    alu_opb    = '0;
    case (state)
      ST_IDLE: begin
        if (cfg_take) begin
          if (cfg_index <= CFG_START_NEG) begin
            state_next = ST_B_VV;
          end
        end else if (in_take) begin
          state_next = (tick_time == '0) ? ST_OUT : ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        state_next = ({2'b00, t_e} >= dur) ? ST_B_VV : ST_D_SEL;
      end
      ST_T_K: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = {24'd0, t_e};
        alu_opb    = {1'b0, dur};
        if (alu_sts.done) begin
          state_next = ST_D_SEL;
        end
      end
      ST_D_SEL: begin
        if (t_e == '0) begin
          state_next = ST_D_FIN;
        end else if (t_e < w_at) begin
          state_next = ST_D_ACC1;
        end else if (e_ep < w_ct) begin
          state_next = ST_D_CRU;
        end else if (e_epp < w_dt) begin
          state_next = ST_D_DEC1;
        end else begin
          state_next = ST_D_FIN;
        end
      end
      ST_D_ACC1: begin
        op_state = 1'b1;
        alu_opa  = {33'd0, a1};
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_ACC2;
        end
      end
      ST_D_ACC2: begin
        op_state = 1'b1;
        alu_opa  = t_x;
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_FIN;
        end
      end
      ST_D_CRU: begin
        op_state = 1'b1;
        alu_opa  = {24'd0, w_pk};
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_FIN;
        end
      end
      ST_D_DEC1: begin
        op_state = 1'b1;
        alu_opa  = {24'd0, w_pk};
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_DEC2;
        end
      end
      ST_D_DEC2: begin
        op_state = 1'b1;
        alu_opa  = {33'd0, b1};
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_DEC3;
        end
      end
      ST_D_DEC3: begin
        op_state = 1'b1;
        alu_opa  = t_x;
        alu_opb  = {3'd0, t_r};
        if (alu_sts.done) begin
          state_next = ST_D_FIN;
        end
      end
      ST_D_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_B_VV: begin
        op_state = 1'b1;
        alu_opa  = {35'd0, v1};
        alu_opb  = {14'd0, v1};
        if (alu_sts.done) begin
          state_next = ST_B_AD;
        end
      end
      ST_B_AD: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = t_x;
        alu_opb    = {11'd0, two_a};
        if (alu_sts.done) begin
          state_next = ST_B_DD;
        end
      end
      ST_B_DD: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = t_x;
        alu_opb    = {11'd0, two_b};
        if (alu_sts.done) begin
          state_next = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        state_next = (ad_dd <= {28'd0, d1}) ? ST_B_CT : ST_B_AB;
      end
      ST_B_CT: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = {19'd0, t_cd, {FRAC_BITS{1'b0}}};
        alu_opb    = {14'd0, v1};
        if (alu_sts.done) begin
          state_next = ST_B_AT;
        end
      end
      ST_B_AB: begin
        op_state = 1'b1;
        alu_opa  = {33'd0, a1};
        alu_opb  = {12'd0, b1};
        if (alu_sts.done) begin
          state_next = ST_B_H;
        end
      end
      ST_B_H: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = t_x;
        alu_opb    = {11'd0, a_plus_b};
        if (alu_sts.done) begin
          state_next = ST_B_DH;
        end
      end
      ST_B_DH: begin
        op_state = 1'b1;
        alu_opa  = t_x;
        alu_opb  = {14'd0, d1};
        if (alu_sts.done) begin
          state_next = ST_B_PK;
        end
      end
      ST_B_PK: begin
        op_state   = 1'b1;
        alu_req.op = ALU_SQRT;
        alu_opa    = {t_x[54:0], 1'b0};
        if (alu_sts.done) begin
          state_next = ST_B_PP;
        end
      end
      ST_B_PP: begin
        op_state = 1'b1;
        alu_opa  = {32'd0, t_pk};
        alu_opb  = {11'd0, t_pk};
        if (alu_sts.done) begin
          state_next = ST_B_AD2;
        end
      end
      ST_B_AD2: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = t_x;
        alu_opb    = {11'd0, two_a};
        if (alu_sts.done) begin
          state_next = ST_B_AT;
        end
      end
      ST_B_AT: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = {16'd0, t_pk, {FRAC_BITS{1'b0}}};
        alu_opb    = {12'd0, a1};
        if (alu_sts.done) begin
          state_next = ST_B_DT;
        end
      end
      ST_B_DT: begin
        op_state   = 1'b1;
        alu_req.op = ALU_DIV;
        alu_opa    = {16'd0, t_pk, {FRAC_BITS{1'b0}}};
        alu_opb    = {12'd0, b1};
        if (alu_sts.done) begin
          state_next = ret_tick ? ST_T_K : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    alu_req.start = op_state && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_B_VV;
    end else begin
      state <= state_next;
    end
  end

  // The unit is started once on entry to each step and the step ends on done.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (alu_req.start) begin
      pend <= 1'b1;
    end else if (alu_sts.done) begin
      pend <= 1'b0;
    end
  end

  tosc_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .req       (alu_req),
    .opa       (alu_opa),
    .opb       (alu_opb),
    .sts       (alu_sts),
    .result    (alu_res),
    .remainder (alu_rem)
  );

  // Configuration and motion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      amp        <= AMP_RST;
      vmax       <= SPEED_RST;
      acc_rate   <= ACCEL_RST;
      dec_rate   <= DECEL_RST;
      offset_now <= '0;
      origin     <= '0;
      seg_len    <= {1'b0, AMP_RST};
      seg_time   <= '0;
      heading    <= 1'b0;
      moved      <= 1'b0;
      ret_tick   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_take) begin
            ret_tick <= 1'b0;
            case (cfg_index)
              CFG_AMPLITUDE: begin
                amp <= cfg_data[19:0];
                if (!moved) begin
                  seg_len <= {1'b0, cfg_data[19:0]};
                end
              end
              CFG_MAX_SPEED:  vmax     <= cfg_data[20:0];
              CFG_ACCEL_RATE: acc_rate <= cfg_data[22:0];
              CFG_DECEL_RATE: dec_rate <= cfg_data[22:0];
              CFG_START_NEG: begin
                if (!moved) begin
                  heading <= cfg_data[0];
                end
              end
              default: begin
              end
            endcase
          end else if (in_take && tick_time != '0) begin
            moved <= 1'b1;
          end
        end
        ST_T_CHK: begin
          if ({2'b00, t_e} >= dur) begin
            // The current segment ends: turn round onto a full swing.
            origin   <= step_end(origin, heading, seg_len);
            heading  <= ~heading;
            seg_len  <= {amp, 1'b0};
            ret_tick <= 1'b1;
          end else begin
            seg_time <= t_e;
          end
        end
        ST_T_K: begin
          if (alu_sts.done) begin
            seg_time <= alu_rem[31:0];
            // An odd count of whole swings leaves us on the far side.
            if (alu_res[0]) begin
              origin  <= step_end(origin, heading, seg_len);
              heading <= ~heading;
            end
          end
        end
        ST_D_FIN: begin
          offset_now <= step_end(origin, heading, t_s);
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and profile words.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        t_e <= (e_sum[32]) ? 32'hFFFF_FFFF : e_sum[31:0];
      end
      ST_T_CHK: begin
        if ({2'b00, t_e} >= dur) begin
          t_e <= t_e - dur[31:0];
        end
      end
      ST_T_K: begin
        if (alu_sts.done) begin
          t_e <= alu_rem[31:0];
        end
      end
      ST_D_SEL: begin
        if (t_e == '0) begin
          t_s <= '0;
        end else if (t_e < w_at) begin
          t_r <= t_e;
        end else if (e_ep < w_ct) begin
          t_r <= e_ep;
        end else if (e_epp < w_dt) begin
          t_r <= e_epp;
        end else begin
          t_s <= d1;
        end
      end
      ST_D_ACC1: begin
        if (alu_sts.done) begin
          t_x <= alu_res[55:0];
        end
      end
      ST_D_ACC2: begin
        if (alu_sts.done) begin
          t_s <= clamp_len({9'd0, alu_res[87:33]}, d1);
        end
      end
      ST_D_CRU: begin
        if (alu_sts.done) begin
          t_s <= clamp_len(cru_sum, d1);
        end
      end
      ST_D_DEC1: begin
        if (alu_sts.done) begin
          t_y <= dec_tot;
        end
      end
      ST_D_DEC2: begin
        if (alu_sts.done) begin
          t_x <= alu_res[55:0];
        end
      end
      ST_D_DEC3: begin
        if (alu_sts.done) begin
          t_s <= clamp_len({14'd0, dec_diff}, d1);
        end
      end
      ST_B_VV, ST_B_AB, ST_B_DH, ST_B_PP: begin
        if (alu_sts.done) begin
          t_x <= alu_res[55:0];
        end
      end
      ST_B_AD, ST_B_AD2: begin
        if (alu_sts.done) begin
          t_ad <= alu_res[47:0];
        end
      end
      ST_B_DD: begin
        if (alu_sts.done) begin
          t_dd <= alu_res[47:0];
        end
      end
      ST_B_CMP: begin
        if (ad_dd <= {28'd0, d1}) begin
          t_pk <= {3'd0, v1};
          t_cd <= d1 - t_ad[20:0] - t_dd[20:0];
        end else begin
          t_cd <= '0;
          t_ct <= '0;
        end
      end
      ST_B_CT: begin
        if (alu_sts.done) begin
          t_ct <= alu_res[47:0];
        end
      end
      ST_B_H: begin
        if (alu_sts.done) begin
          t_x <= {8'd0, alu_res[47:0]};
        end
      end
      ST_B_PK: begin
        if (alu_sts.done) begin
          t_pk <= alu_res[23:0];
        end
      end
      ST_B_AT: begin
        if (alu_sts.done) begin
          w_at <= sat32({16'd0, alu_res[47:0]});
        end
      end
      ST_B_DT: begin
        if (alu_sts.done) begin
          w_dt <= sat32({16'd0, alu_res[47:0]});
          w_pk <= {8'd0, t_pk};
          w_ad <= sat32({16'd0, t_ad});
          w_cd <= {11'd0, t_cd};
          w_ct <= sat32({16'd0, t_ct});
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one result beat while the next tick is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      position_offset <= offset_now;
      moving_negative <= heading;
      phase           <= phase_now;
    end
  end

  // Checks on the sequencer and the shared unit.
  `include "assert_macros.svh"

  `ASSERT_IMPL(a_idle_unit_free, clk, rst, in_ready, !alu_sts.busy, "unit busy while idle")
  `ASSERT_IMPL(a_pend_in_step, clk, rst, pend, op_state, "unit pending outside a step")
  `ASSERT_NEXT(a_zero_tick_hold, clk, rst, in_take && (tick_time == '0), $stable(seg_time), "zero tick moved time")
  `ASSERT_IMPL(a_result_source, clk, rst, $rose(out_valid), $past(state) == ST_OUT, "result from wrong step")

endmodule

// ===== tb/oscillation_checker.sv =====
// ----------------------------------------------------------------------------
// oscillation_checker
// Watches the tick, result and register channels of the oscillation profile
// block, predicts each result from its own copy of the state and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oscillation_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        tick_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [21:0] position_offset,
  input  logic               moving_negative,
  input  logic [1:0]         phase,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import tosc_pkg::*;

  typedef struct packed {
    logic signed [21:0] offset;
    logic               neg;
    logic [1:0]         ph;
  } motion_t;

  motion_t expected_motion[$];

  logic [63:0] amp_r, speed_r, accel_r, decel_r;
  logic        startneg_r;
  logic signed [63:0] pos_now, origin;
  logic [63:0] seg_len, seg_time;
  logic        heading, has_moved;
  logic [31:0] acc_t, cru_t, dec_t, peak, acc_d, cru_d;

  function automatic logic [63:0] one_min(input logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] prod_shift(input logic [63:0] x, input logic [63:0] y,
                                             input int s);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p >> s;
    return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] move_end(input logic signed [63:0] o, input logic n,
                                                  input logic [63:0] l);
    logic signed [63:0] r;
    r = n ? o - $signed(l) : o + $signed(l);
    if (r > 64'sd2097151) return 64'sd2097151;
    if (r < -64'sd2097152) return -64'sd2097152;
    return r;
  endfunction

  task automatic plan_segment(input logic [63:0] len);
    logic [63:0] v, a, b, d, ad, dd, pk, cd, ct, h;
    v = one_min(speed_r);
    a = one_min(accel_r);
    b = one_min(decel_r);
    d = one_min(len);
    ad = (v * v) / (2 * a);
    dd = (v * v) / (2 * b);
    cd = 0;
    ct = 0;
    if (ad + dd <= d) begin
      pk = v;
      cd = d - ad - dd;
      ct = (cd << FRAC_BITS) / v;
    end else begin
      h = (a * b) / (a + b);
      pk = root64(2 * d * h);
      ad = (pk * pk) / (2 * a);
    end
    acc_t = clip32((pk << FRAC_BITS) / a);
    dec_t = clip32((pk << FRAC_BITS) / b);
    cru_t = clip32(ct);
    peak = clip32(pk);
    acc_d = clip32(ad);
    cru_d = clip32(cd);
  endtask

  function automatic logic [63:0] seg_span();
    logic [63:0] s;
    s = 64'(acc_t) + 64'(cru_t) + 64'(dec_t);
    return (s == 0) ? 64'd1 : s;
  endfunction

  function automatic logic [63:0] travel_at(input logic [63:0] e, input logic [63:0] len);
    logic [63:0] d, a, b, tot, q, r;
    d = one_min(len);
    a = one_min(accel_r);
    b = one_min(decel_r);
    if (e == 0) return 0;
    if (e < acc_t) begin
      r = prod_shift(a * e, e, 2 * FRAC_BITS + 1);
      return (r < d) ? r : d;
    end
    e = e - acc_t;
    if (e < cru_t) begin
      r = 64'(acc_d) + ((64'(peak) * e) >> FRAC_BITS);
      return (r < d) ? r : d;
    end
    e = e - cru_t;
    if (e < dec_t) begin
      tot = 64'(acc_d) + 64'(cru_d) + ((64'(peak) * e) >> FRAC_BITS);
      q = prod_shift(b * e, e, 2 * FRAC_BITS + 1);
      r = (q > tot) ? 0 : tot - q;
      return (r < d) ? r : d;
    end
    return d;
  endfunction

  function automatic logic [1:0] phase_of(input logic [63:0] e);
    if (e == 0 || e < acc_t) return PH_ACCEL;
    e = e - acc_t;
    if (e < cru_t) return PH_CRUISE;
    return PH_DECEL;
  endfunction

  task automatic advance(input logic [15:0] tick);
    logic [63:0] e, dur, k;
    motion_t m;
    if (tick != 0) begin
      e = seg_time + tick;
      has_moved = 1'b1;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      plan_segment(seg_len);
      dur = seg_span();
      if (e >= dur) begin
        e = e - dur;
        origin = move_end(origin, heading, seg_len);
        heading = !heading;
        seg_len = (2 * amp_r) & 64'h1F_FFFF;
        plan_segment(seg_len);
        dur = seg_span();
        k = e / dur;
        e = e % dur;
        if (k[0]) begin
          origin = move_end(origin, heading, seg_len);
          heading = !heading;
        end
      end
      seg_time = e;
      pos_now = move_end(origin, heading, travel_at(e, seg_len));
    end
    m.offset = pos_now[21:0];
    m.neg = heading;
    m.ph = phase_of(seg_time);
    expected_motion.push_back(m);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      CFG_AMPLITUDE: begin
        amp_r = val & 32'hF_FFFF;
        if (!has_moved) seg_len = amp_r;
      end
      CFG_MAX_SPEED:  speed_r = val & 32'h1F_FFFF;
      CFG_ACCEL_RATE: accel_r = val & 32'h7F_FFFF;
      CFG_DECEL_RATE: decel_r = val & 32'h7F_FFFF;
      CFG_START_NEG: begin
        startneg_r = val[0];
        if (!has_moved) heading = startneg_r;
      end
      default: return;
    endcase
    plan_segment(seg_len);
  endtask

  assign pending = expected_motion.size();

  always @(posedge clk) begin
    motion_t m;
    int      bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      amp_r = AMP_RST;
      speed_r = SPEED_RST;
      accel_r = ACCEL_RST;
      decel_r = DECEL_RST;
      startneg_r = 1'b0;
      pos_now = 0;
      origin = 0;
      seg_len = amp_r;
      seg_time = 0;
      heading = 1'b0;
      has_moved = 1'b0;
      plan_segment(seg_len);
      expected_motion.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (expected_motion.size() == 0) begin
          $error("result beat with nothing expected");
          bad = bad + 1;
        end else begin
          m = expected_motion.pop_front();
          if (position_offset !== m.offset) begin
            $error("position_offset expected %0d actual %0d", m.offset, position_offset);
            bad = bad + 1;
          end
          if (moving_negative !== m.neg) begin
            $error("moving_negative expected %0d actual %0d", m.neg, moving_negative);
            bad = bad + 1;
          end
          if (phase !== m.ph) begin
            $error("phase expected %0d actual %0d", m.ph, phase);
            bad = bad + 1;
          end
        end
      end
      if (in_valid && in_ready) advance(tick_time);
      errors <= errors + bad;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the oscillation profile block under
// several settings and idling patterns; the checker compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tosc_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        tick_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [21:0] position_offset;
  logic               moving_negative;
  logic [1:0]         phase;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 errors;
  int                 pending;

  // Idle rates in percent for the sender and the receiver.
  int send_idle = 0;
  int recv_idle = 0;
  int ticks_sent = 0;

  always #10 clk = ~clk;

  trapezoid_oscillation_profile u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .tick_time(tick_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_offset(position_offset), .moving_negative(moving_negative), .phase(phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  oscillation_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .tick_time(tick_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_offset(position_offset), .moving_negative(moving_negative), .phase(phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // The receiver stalls at random, drawn afresh on every edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // One tick beat: optional idle gap first, then valid held until accepted.
  // Valid drops for the edge after acceptance, while the block is busy anyway.
  task automatic send_tick(input logic [15:0] t);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    tick_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    ticks_sent++;
    @(posedge clk);
  endtask

  // Waits until every result is in, then leaves a quiet gap before the
  // next register writes.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [31:0] amp, input logic [31:0] spd,
                              input logic [31:0] acc, input logic [31:0] dec,
                              input logic [31:0] neg);
    write_cfg(CFG_AMPLITUDE, amp);
    write_cfg(CFG_MAX_SPEED, spd);
    write_cfg(CFG_ACCEL_RATE, acc);
    write_cfg(CFG_DECEL_RATE, dec);
    write_cfg(CFG_START_NEG, neg);
  endtask

  // Mostly short ticks so segments play out over many beats, with some
  // zero ticks and some full-range ones that cross several segments.
  function automatic logic [15:0] pick_tick();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'd0;
    if (r < 70) return 16'($urandom_range(4000));
    if (r < 80) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_tick(pick_tick());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: before any motion, amplitude and direction load the segment.
    write_cfg(CFG_START_NEG, 32'd1);
    write_cfg(CFG_AMPLITUDE, 32'd65536);
    send_tick(16'd0);
    send_tick(16'd1);
    send_tick(16'd1000);
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    drain();
    // A direction write after motion has no effect; an unknown index is ignored.
    write_cfg(CFG_START_NEG, 32'd0);
    write_cfg(3'd7, 32'hFFFF_FFFF);
    send_tick(16'd20000);
    drain();

    // Zero registers count as one LSB; tiny lengths end many segments per tick.
    load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_tick(16'd1);
    send_tick(16'hFFFF);
    send_tick(16'd2);
    drain();
    // Largest values everywhere: saturating offsets and triangular profiles.
    load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    for (int i = 0; i < 6; i++) send_tick(16'hFFFF);
    drain();
    // Slow acceleration with a long segment: very long time spans.
    load_setting(32'd524288, 32'd1048576, 32'd1, 32'd4194304, 32'd0);
    for (int i = 0; i < 4; i++) send_tick(16'hFFFF);
    drain();

    // Random part in three idling regimes, each under three fresh settings.
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 33 : (p == 1) ? 55 : 0;
      recv_idle = (p == 0) ? 55 : (p == 1) ? 33 : 0;
      for (int s = 0; s < 3; s++) begin
        load_setting($urandom_range(524288, 1), $urandom_range(1048576, 1),
                     $urandom_range(4194304, 1), $urandom_range(4194304, 1),
                     $urandom_range(1));
        random_phase(115);
        drain();
      end
    end

    $display("Covered %0d ticks over directed extremes and twelve register settings,",
             ticks_sent);
    $display("with sender and receiver stalls in both proportions and without.");
    if (errors == 0) begin
      $display("PASS trapezoid_oscillation_profile");
    end else begin
      $display("FAIL trapezoid_oscillation_profile");
    end
    $finish;
  end

  // Worst case is roughly a thousand ticks, each with its stalls and
  // rebuilds; this leaves ample room over that.
  initial begin
    #400ms;
    $display("FAIL trapezoid_oscillation_profile");
    $finish;
  end

endmodule
